>>> rtl/bhbc_pkg.sv
// ----------------------------------------------------------------------------
// bhbc_pkg: shared types and constants of the burst holding backoff controller
// Field widths, operation codes, command/status bundles and elaboration-time
// tables (exponent factors, queue id wrap).
// ----------------------------------------------------------------------------
`default_nettype none

package bhbc_pkg;

    localparam int NUM_QUEUES_DEF = 16;
    localparam int MAX_HOLD_DEF   = 65535;

    localparam int ACT_W   = 2;
    localparam int QID_W   = 4;
    localparam int QSIZE_W = 10;
    localparam int SUCC_W  = 11;
    localparam int DUR_W   = 12;
    localparam int DEC_W   = 2;
    localparam int WIN_W   = 10;
    localparam int AIFS_W  = 2;
    localparam int HOLD_W  = 16;
    localparam int INT_W   = 40;
    localparam int GAIN_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_QUEUE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RL_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RL_WINDOW   = 3'd5;

    localparam logic [ACT_W-1:0] ACT_NOTE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SUCCESS = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FAILURE = 2'd3;

    localparam logic [DEC_W-1:0] DEC_NOTED     = 2'd0;
    localparam logic [DEC_W-1:0] DEC_CONTEND   = 2'd1;
    localparam logic [DEC_W-1:0] DEC_IMMEDIATE = 2'd2;
    localparam logic [DEC_W-1:0] DEC_ENDED     = 2'd3;

    localparam logic [AIFS_W-1:0] AIFS_NORMAL    = 2'd2;
    localparam logic [AIFS_W-1:0] AIFS_IMMEDIATE = 2'd0;

    // datapath widths
    localparam int X_W       = 26;   // step_gain * queue, Q.16
    localparam int Y_W       = 27;   // x * log2(e), Q.16
    localparam int R_W       = 31;   // 2^frac in Q1.30
    localparam int DIVD_W    = 49;   // knee_offset << 33
    localparam int DIV_STEPS = 49;
    localparam int EXP_STEPS = 16;
    localparam int STEP_W    = 4;
    localparam int CNT_W     = 6;
    localparam int PROD_W    = 51;   // intensity * success_window
    localparam int INC_W     = 35;

    localparam logic [16:0]      LOG2E_Q16     = 17'd94548;
    localparam logic [INT_W-1:0] INTENSITY_MAX = {INT_W{1'b1}};

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_NOTE      = 4'd2;
    localparam logic [OP_W-1:0] OP_IGNORE    = 4'd3;
    localparam logic [OP_W-1:0] OP_START_RL  = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_X     = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_Y     = 4'd6;
    localparam logic [OP_W-1:0] OP_EXP_INIT  = 4'd7;
    localparam logic [OP_W-1:0] OP_EXP_STEP  = 4'd8;
    localparam logic [OP_W-1:0] OP_EXP_SCALE = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd10;
    localparam logic [OP_W-1:0] OP_WINDOW    = 4'd11;
    localparam logic [OP_W-1:0] OP_FAIL      = 4'd12;
    localparam logic [OP_W-1:0] OP_HOLD_RD   = 4'd13;
    localparam logic [OP_W-1:0] OP_HOLD_SUM  = 4'd14;
    localparam logic [OP_W-1:0] OP_SETTLE    = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STEP_W-1:0] step;
    } bhbc_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             in_burst;
        logic             first_pending;
        logic             rl_mode;
        logic             k_sat;
    } bhbc_stat_t;

    typedef struct packed {
        logic [QSIZE_W-1:0] min_queue;
        logic [GAIN_W-1:0]  step_gain;
        logic [GAIN_W-1:0]  knee_offset;
        logic [WIN_W-1:0]   max_window;
        logic               rl_mode;
        logic [WIN_W-1:0]   rl_window;
    } bhbc_cfg_t;

    localparam int QTAB_LANE = 8;
    localparam int QTAB_W    = (1 << QID_W) * QTAB_LANE;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // factors 2^(2^-i), i = 1..16, in Q1.30
    function automatic logic [EXP_STEPS*R_W-1:0] exp_factor_table();
        logic [63:0]              c;
        logic [EXP_STEPS*R_W-1:0] t;
        c = 64'd2 << 30;
        t = '0;
        for (int i = 0; i < EXP_STEPS; i++) begin
            c = isqrt64(c << 30);
            t[i*R_W +: R_W] = c[R_W-1:0];
        end
        return t;
    endfunction

    localparam logic [EXP_STEPS*R_W-1:0] EXP_FACTORS = exp_factor_table();

    // queue id wrapped into the queue count, one lane per id
    function automatic logic [QTAB_W-1:0] qid_wrap_table(input int n);
        int                v;
        logic [QTAB_W-1:0] t;
        t = '0;
        for (int id = 0; id < (1 << QID_W); id++) begin
            v = id;
            for (int j = 0; j < (1 << QID_W); j++) begin
                if (v >= n) begin
                    v = v - n;
                end
            end
            t[id*QTAB_LANE +: QTAB_LANE] = v[QTAB_LANE-1:0];
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bhbc_ctrl.sv
// ----------------------------------------------------------------------------
// bhbc_ctrl: sequencing state machine
// Accepts one transaction at a time, steps the datapath through the exponent,
// division and holding sequences, and commits a result when the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbc_ctrl
    import bhbc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       out_free,
    input  wire bhbc_stat_t stat,
    output bhbc_cmd_t       cmd,
    output logic            res_load
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_MULY     = 4'd2;
    localparam logic [3:0] S_EXPCHK   = 4'd3;
    localparam logic [3:0] S_EXP      = 4'd4;
    localparam logic [3:0] S_SCALE    = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_WIN      = 4'd7;
    localparam logic [3:0] S_HSUM     = 4'd8;
    localparam logic [3:0] S_SETTLE   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0]  term_op;
    logic             term;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.step   = cnt_reg[STEP_W-1:0];
        term       = 1'b0;
        term_op    = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.action)
                    ACT_NOTE: begin
                        term    = 1'b1;
                        term_op = OP_NOTE;
                    end
                    ACT_START: begin
                        if (stat.in_burst) begin
                            term    = 1'b1;
                            term_op = OP_IGNORE;
                        end else if (stat.rl_mode) begin
                            term    = 1'b1;
                            term_op = OP_START_RL;
                        end else begin
                            cmd.op     = OP_MUL_X;
                            state_next = S_MULY;
                        end
                    end
                    ACT_SUCCESS: begin
                        if (!stat.in_burst) begin
                            term    = 1'b1;
                            term_op = OP_IGNORE;
                        end else if (!stat.rl_mode && stat.first_pending) begin
                            cmd.op     = OP_HOLD_RD;
                            state_next = S_HSUM;
                        end else begin
                            term    = 1'b1;
                            term_op = OP_SETTLE;
                        end
                    end
                    default: begin
                        term    = 1'b1;
                        term_op = stat.in_burst ? OP_FAIL : OP_IGNORE;
                    end
                endcase
            end
            S_MULY: begin
                cmd.op     = OP_MUL_Y;
                state_next = S_EXPCHK;
            end
            S_EXPCHK: begin
                cmd.op     = OP_EXP_INIT;
                cnt_next   = '0;
                state_next = stat.k_sat ? S_SCALE : S_EXP;
            end
            S_EXP: begin
                cmd.op = OP_EXP_STEP;
                if (cnt_reg == CNT_W'(EXP_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_SCALE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCALE: begin
                cmd.op     = OP_EXP_SCALE;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_WIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WIN: begin
                term    = 1'b1;
                term_op = OP_WINDOW;
            end
            S_HSUM: begin
                cmd.op     = OP_HOLD_SUM;
                state_next = S_SETTLE;
            end
            S_SETTLE: begin
                term    = 1'b1;
                term_op = OP_SETTLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // commit only into a free output register; otherwise hold here
        res_load = term && out_free;
        if (res_load) begin
            cmd.op     = term_op;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bhbc_dp.sv
// ----------------------------------------------------------------------------
// bhbc_dp: controller datapath
// Input latch, exponent and division units, window rounding, holding update,
// per-queue deficit memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bhbc_dp
    import bhbc_pkg::*;
#(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int MAX_HOLD   = MAX_HOLD_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bhbc_cfg_t          cfg,
    input  wire bhbc_cmd_t          cmd,
    input  wire logic [ACT_W-1:0]   in_action,
    input  wire logic [QID_W-1:0]   in_queue_id,
    input  wire logic [QSIZE_W-1:0] in_queue_size,
    input  wire logic [SUCC_W-1:0]  in_success_window,
    input  wire logic [DUR_W-1:0]   in_duration_slots,
    input  wire logic               in_queue_empty,
    output bhbc_stat_t              stat,
    output logic [DEC_W-1:0]        res_decision,
    output logic [WIN_W-1:0]        res_window,
    output logic [AIFS_W-1:0]       res_aifs,
    output logic [HOLD_W-1:0]       res_holding
);

    localparam int AQ_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [QTAB_W-1:0] QID_TABLE = qid_wrap_table(NUM_QUEUES);
    localparam logic [HOLD_W-1:0] HOLD_CAP  = HOLD_W'(MAX_HOLD);

    // latched item
    logic [ACT_W-1:0]   act_reg;
    logic [QID_W-1:0]   qid_reg;
    logic [QSIZE_W-1:0] qsize_reg;
    logic [SUCC_W-1:0]  succ_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic               empty_reg;

    // arithmetic registers
    logic [X_W-1:0]    x_reg;
    logic [Y_W-1:0]    y_reg;
    logic [R_W-1:0]    r_reg;
    logic [INT_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [PROD_W-1:0] hprod_reg;
    logic [HOLD_W-1:0] def_reg;
    logic              def_vld_reg;

    // burst state
    logic [AQ_W-1:0]   aq_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [INT_W-1:0]  int_reg;
    logic              in_burst_reg;
    logic              first_reg;
    logic [DUR_W-1:0]  prior_reg;

    logic [HOLD_W-1:0]     mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] vld_reg;

    logic [DEC_W-1:0]  dec_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [AIFS_W-1:0] aifs_reg;
    logic [HOLD_W-1:0] hout_reg;

    // exponent
    logic [QSIZE_W-1:0] q_clamp;
    logic [X_W-1:0]     x_prod;
    logic [42:0]        y_full;
    logic [10:0]        k_int;
    logic [4:0]         k_lo;
    logic [3:0]         rsh;
    logic               k_sat;
    logic [R_W-1:0]     factor;
    logic [61:0]        r_prod;
    logic               f_bit;
    logic [INT_W-1:0]   scaled;

    // division and window
    logic [INT_W:0]   rem_sh;
    logic             div_ge;
    logic [49:0]      raw;
    logic             raw_big;
    logic [9:0]       raw_int;
    logic [3:0]       msb_pos;
    logic [10:0]      cw;
    logic [10:0]      cw_fin;
    logic [10:0]      cw_m1;
    logic [26:0]      cw_diff;
    logic [26:0]      cw_quarter;
    logic [WIN_W-1:0] win_calc;

    // holding
    logic [AQ_W-1:0]   aq_new;
    logic [INT_W:0]    inc_lo_sum;
    logic [51:0]       inc_hi_sum;
    logic [INC_W-1:0]  inc;
    logic [HOLD_W-1:0] deficit;
    logic [INC_W:0]    hsum;
    logic [HOLD_W-1:0] hold_sum;
    logic [HOLD_W-1:0] hbase;
    logic [HOLD_W-1:0] hsettled;
    logic              keep;

    assign stat.action        = act_reg;
    assign stat.in_burst      = in_burst_reg;
    assign stat.first_pending = first_reg;
    assign stat.rl_mode       = cfg.rl_mode;
    assign stat.k_sat         = k_sat;

    assign res_decision = dec_reg;
    assign res_window   = win_reg;
    assign res_aifs     = aifs_reg;
    assign res_holding  = hout_reg;

    assign aq_new = QID_TABLE[{qid_reg, 3'b000} +: AQ_W];

    always_comb begin
        q_clamp = (qsize_reg > cfg.min_queue) ? qsize_reg : cfg.min_queue;
        x_prod  = X_W'(cfg.step_gain) * X_W'(q_clamp);
        y_full  = 43'(x_reg) * 43'(LOG2E_Q16) + 43'd32768;
        k_int   = y_reg[Y_W-1:16];
        k_lo    = k_int[4:0];
        k_sat   = (k_int >= 11'd24);
        factor  = EXP_FACTORS[cmd.step*R_W +: R_W];
        r_prod  = 62'(r_reg) * 62'(factor) + (62'd1 << 29);
        f_bit   = y_reg[4'd15 - cmd.step];
        rsh     = 4'(5'd14 - k_lo);
        if (k_sat) begin
            scaled = INTENSITY_MAX;
        end else if (k_lo < 5'd14) begin
            scaled = (INT_W'(r_reg) + (40'd1 << (rsh - 4'd1))) >> rsh;
        end else begin
            scaled = INT_W'(r_reg) << (k_lo - 5'd14);
        end
    end

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
        div_ge  = (rem_sh >= {1'b0, int_reg});
        raw     = 50'(quo_reg) + (50'd1 << 17);
        raw_big = |raw[49:26];
        raw_int = raw[25:16];
        msb_pos = '0;
        for (int i = 0; i < 10; i++) begin
            if (raw_int[i]) begin
                msb_pos = 4'(i);
            end
        end
        cw         = 11'd1 << (msb_pos + 4'd1);
        cw_diff    = {cw, 16'd0} - raw[26:0];
        cw_quarter = {2'b00, cw[10:2], 16'd0};
        cw_fin     = (cw_diff > cw_quarter) ? (cw >> 1) : cw;
        cw_m1      = cw_fin - 11'd1;
        if (raw_big || (cw_m1 > {1'b0, cfg.max_window})) begin
            win_calc = cfg.max_window;
        end else begin
            win_calc = cw_m1[WIN_W-1:0];
        end
    end

    always_comb begin
        inc_lo_sum = {1'b0, int_reg} + 41'd32768;
        inc_hi_sum = 52'(hprod_reg) + 52'd65536;
        if (succ_reg <= 11'd2) begin
            inc = INC_W'(inc_lo_sum[INT_W:16]);
        end else begin
            inc = inc_hi_sum[51:17];
        end
        deficit  = def_vld_reg ? def_reg : '0;
        hsum     = (INC_W+1)'(deficit) + (INC_W+1)'(inc);
        hold_sum = (hsum > (INC_W+1)'(HOLD_CAP)) ? HOLD_CAP : hsum[HOLD_W-1:0];
        hbase    = cfg.rl_mode ? '0 : hold_reg;
        hsettled = (hbase > HOLD_W'(prior_reg)) ? hbase - HOLD_W'(prior_reg) : '0;
        keep     = !empty_reg && (hsettled >= HOLD_W'(dur_reg));
    end

    // burst state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aq_reg       <= '0;
            hold_reg     <= '0;
            int_reg      <= '0;
            in_burst_reg <= 1'b0;
            first_reg    <= 1'b1;
            prior_reg    <= '0;
            vld_reg      <= '0;
        end else begin
            case (cmd.op)
                OP_NOTE: begin
                    prior_reg <= dur_reg;
                end
                OP_START_RL: begin
                    aq_reg       <= aq_new;
                    in_burst_reg <= 1'b1;
                    first_reg    <= 1'b1;
                    int_reg      <= '0;
                end
                OP_EXP_SCALE: begin
                    int_reg <= scaled;
                end
                OP_WINDOW: begin
                    aq_reg       <= aq_new;
                    in_burst_reg <= 1'b1;
                    first_reg    <= 1'b1;
                end
                OP_HOLD_SUM: begin
                    hold_reg <= hold_sum;
                end
                OP_SETTLE: begin
                    if (keep) begin
                        hold_reg  <= hsettled;
                        first_reg <= 1'b0;
                    end else begin
                        vld_reg[aq_reg] <= 1'b1;
                        hold_reg        <= '0;
                        aq_reg          <= '0;
                        int_reg         <= '0;
                        in_burst_reg    <= 1'b0;
                        first_reg       <= 1'b1;
                    end
                end
                OP_FAIL: begin
                    vld_reg[aq_reg] <= 1'b1;
                    hold_reg        <= '0;
                    aq_reg          <= '0;
                    int_reg         <= '0;
                    in_burst_reg    <= 1'b0;
                    first_reg       <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // deficit memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FAIL) begin
            mem[aq_reg] <= hold_reg;
        end else if (cmd.op == OP_SETTLE && !keep) begin
            mem[aq_reg] <= hsettled;
        end
        if (cmd.op == OP_HOLD_RD) begin
            def_reg     <= mem[aq_reg];
            def_vld_reg <= vld_reg[aq_reg];
        end
    end

    // item latch, arithmetic and results
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                act_reg   <= in_action;
                qid_reg   <= in_queue_id;
                qsize_reg <= in_queue_size;
                succ_reg  <= in_success_window;
                dur_reg   <= in_duration_slots;
                empty_reg <= in_queue_empty;
            end
            OP_MUL_X: begin
                x_reg <= x_prod;
            end
            OP_MUL_Y: begin
                y_reg <= y_full[42:16];
            end
            OP_EXP_INIT: begin
                r_reg   <= R_W'(1) << 30;
                rem_reg <= '0;
                quo_reg <= {cfg.knee_offset, 33'd0};
            end
            OP_EXP_STEP: begin
                if (f_bit) begin
                    r_reg <= r_prod[60:30];
                end
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? INT_W'(rem_sh - {1'b0, int_reg}) : rem_sh[INT_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], div_ge};
            end
            OP_HOLD_RD: begin
                hprod_reg <= PROD_W'(int_reg) * PROD_W'(succ_reg);
            end
            default: begin
            end
        endcase
        case (cmd.op)
            OP_NOTE, OP_IGNORE: begin
                dec_reg  <= (act_reg == ACT_NOTE || act_reg == ACT_START) ?
                            DEC_NOTED : DEC_ENDED;
                win_reg  <= '0;
                aifs_reg <= AIFS_NORMAL;
                hout_reg <= hold_reg;
            end
            OP_START_RL: begin
                dec_reg  <= DEC_CONTEND;
                win_reg  <= cfg.rl_window;
                aifs_reg <= AIFS_NORMAL;
                hout_reg <= hold_reg;
            end
            OP_WINDOW: begin
                dec_reg  <= DEC_CONTEND;
                win_reg  <= win_calc;
                aifs_reg <= AIFS_NORMAL;
                hout_reg <= hold_reg;
            end
            OP_FAIL: begin
                dec_reg  <= DEC_ENDED;
                win_reg  <= '0;
                aifs_reg <= AIFS_NORMAL;
                hout_reg <= '0;
            end
            OP_SETTLE: begin
                dec_reg  <= keep ? DEC_IMMEDIATE : DEC_ENDED;
                win_reg  <= '0;
                aifs_reg <= keep ? AIFS_IMMEDIATE : AIFS_NORMAL;
                hout_reg <= keep ? hsettled : '0;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/burst_holding_backoff_controller_unit.sv
// Sequence: note, ignored, failure and later-success transactions commit from dispatch;
// a first success outside rl mode first reads the deficit memory and sums the holding;
// a burst start outside rl mode runs 16 exponent steps on one 31x31 multiplier (none if
// the exponent saturates), then a 49-step divider; a full output stalls the commit.
// Throughput: one transaction in flight; the next is accepted the cycle after commit.
// Reset: synchronous active-low aresetn restores register defaults and clears bursts.
// ----------------------------------------------------------------------------
// burst_holding_backoff_controller_unit: per-link burst controller top level
// Configuration registers, output register and the controller/datapath pair.
// ----------------------------------------------------------------------------
`default_nettype none

module burst_holding_backoff_controller_unit
    import bhbc_pkg::*;
#(
    parameter int NUM_QUEUES = NUM_QUEUES_DEF,
    parameter int MAX_HOLD   = MAX_HOLD_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input transactions
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ACT_W-1:0]      s_action,
    input  wire logic [QID_W-1:0]      s_queue_id,
    input  wire logic [QSIZE_W-1:0]    s_queue_size,
    input  wire logic [SUCC_W-1:0]     s_success_window,
    input  wire logic [DUR_W-1:0]      s_duration_slots,
    input  wire logic                  s_queue_empty,
    // result transactions
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DEC_W-1:0]           m_decision,
    output logic [WIN_W-1:0]           m_window_out,
    output logic [AIFS_W-1:0]          m_aifs_number,
    output logic [HOLD_W-1:0]          m_holding_slots
);

    bhbc_cfg_t  cfg_reg;
    bhbc_cmd_t  cmd;
    bhbc_stat_t stat;
    logic       res_load;
    logic       out_free;
    logic       m_valid_reg, m_valid_next;

    // Register writes are always taken; software writes only while idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_queue   <= 10'd1;
            cfg_reg.step_gain   <= 16'd655;
            cfg_reg.knee_offset <= 16'd500;
            cfg_reg.max_window  <= 10'd1023;
            cfg_reg.rl_mode     <= 1'b0;
            cfg_reg.rl_window   <= 10'd15;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_QUEUE:   cfg_reg.min_queue   <= cfg_data[QSIZE_W-1:0];
                REG_STEP_GAIN:   cfg_reg.step_gain   <= cfg_data;
                REG_KNEE_OFFSET: cfg_reg.knee_offset <= cfg_data;
                REG_MAX_WINDOW:  cfg_reg.max_window  <= cfg_data[WIN_W-1:0];
                REG_RL_MODE:     cfg_reg.rl_mode     <= cfg_data[0];
                REG_RL_WINDOW:   cfg_reg.rl_window   <= cfg_data[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The output register frees when its transaction is taken, so a new
    // result may be committed in the same cycle the old one leaves.
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = res_load || (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Sequencer: accepts, steps the datapath, commits the result.
    bhbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .res_load (res_load)
    );

    // Datapath: the result registers drive the m_ payload directly and
    // change only on a commit, which the sequencer holds while stalled.
    bhbc_dp #(
        .NUM_QUEUES (NUM_QUEUES),
        .MAX_HOLD   (MAX_HOLD)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .cmd               (cmd),
        .in_action         (s_action),
        .in_queue_id       (s_queue_id),
        .in_queue_size     (s_queue_size),
        .in_success_window (s_success_window),
        .in_duration_slots (s_duration_slots),
        .in_queue_empty    (s_queue_empty),
        .stat              (stat),
        .res_decision      (m_decision),
        .res_window        (m_window_out),
        .res_aifs          (m_aifs_number),
        .res_holding       (m_holding_slots)
    );

    // A commit never overwrites a result that is still waiting.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_ready))
        else $error("result committed over a pending transaction");

    // Acceptance and commit never share a cycle.
    a_accept_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !res_load)
        else $error("accept and commit in the same cycle");

    // After an accept the block is not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after an accept");

endmodule

`default_nettype wire
